// ----- rtl/arct_pkg.sv -----
// Shared types and codes for the address range claim table.
// No dependencies; used by every module of the block.
`default_nettype none

package arct_pkg;

  localparam int unsigned TableEntriesDefault = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 6;

  localparam logic CMD_CLAIM   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_ORDER     = 3'd1;
  localparam logic [StatusW-1:0] ST_OVERLAP   = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;

  // Table update issued by the decision logic for one request.
  typedef struct packed {
    logic             claim;
    logic             release_en;
    logic [SlotW-1:0] slot;
  } upd_t;

  // Lookup results of one request against the table.
  typedef struct packed {
    logic             overlap_any;
    logic             free_hit;
    logic [SlotW-1:0] free_slot;
    logic             exact_hit;
    logic [SlotW-1:0] exact_slot;
  } lkp_t;

endpackage

`default_nettype wire

// ----- rtl/arct_table.sv -----
// Range storage: used marks, start and end address per slot.
// Depends on arct_pkg for widths and the update struct.
`default_nettype none

module arct_table #(
  parameter int unsigned TableEntries = arct_pkg::TableEntriesDefault
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire arct_pkg::upd_t                           upd_i,
  input  wire logic [arct_pkg::AddrW-1:0]               lo_i,
  input  wire logic [arct_pkg::AddrW-1:0]               hi_i,
  output logic      [TableEntries-1:0]                  used_o,
  output logic      [TableEntries-1:0][arct_pkg::AddrW-1:0] start_o,
  output logic      [TableEntries-1:0][arct_pkg::AddrW-1:0] end_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  logic [TableEntries-1:0]                      used_q, used_d;
  logic [TableEntries-1:0][arct_pkg::AddrW-1:0] start_q;
  logic [TableEntries-1:0][arct_pkg::AddrW-1:0] end_q;
  logic [IdxW-1:0]                              idx;

  assign idx = upd_i.slot[IdxW-1:0];

  always_comb begin
    used_d = used_q;
    if (upd_i.claim) begin
      used_d[idx] = 1'b1;
    end else if (upd_i.release_en) begin
      used_d[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Address words carry no reset; they are read only behind a used mark.
  always_ff @(posedge clk_i) begin
    if (upd_i.claim) begin
      start_q[idx] <= lo_i;
      end_q[idx]   <= hi_i;
    end
  end

  assign used_o  = used_q;
  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

`default_nettype wire

// ----- rtl/arct_match.sv -----
// Parallel compare of one request against every slot, with lowest-slot encoders.
// Depends on arct_pkg for widths and the lookup struct.
`default_nettype none

module arct_match #(
  parameter int unsigned TableEntries = arct_pkg::TableEntriesDefault
) (
  input  wire logic [arct_pkg::AddrW-1:0]                   lo_i,
  input  wire logic [arct_pkg::AddrW-1:0]                   hi_i,
  input  wire logic [TableEntries-1:0]                      used_i,
  input  wire logic [TableEntries-1:0][arct_pkg::AddrW-1:0] start_i,
  input  wire logic [TableEntries-1:0][arct_pkg::AddrW-1:0] end_i,
  output arct_pkg::lkp_t                                    lkp_o
);

  logic [TableEntries-1:0] overlap;
  logic [TableEntries-1:0] exact;

  always_comb begin
    for (int k = 0; k < TableEntries; k++) begin
      // Inclusive ranges meet unless one ends before the other begins.
      overlap[k] = used_i[k] && !((hi_i < start_i[k]) || (end_i[k] < lo_i));
      exact[k]   = used_i[k] && (start_i[k] == lo_i) && (end_i[k] == hi_i);
    end
  end

  always_comb begin
    lkp_o             = '0;
    lkp_o.overlap_any = |overlap;
    lkp_o.free_hit    = ~&used_i;
    lkp_o.exact_hit   = |exact;
    // Walk down so the lowest hit wins.
    for (int k = TableEntries - 1; k >= 0; k--) begin
      if (!used_i[k]) begin
        lkp_o.free_slot = arct_pkg::SlotW'(k);
      end
      if (exact[k]) begin
        lkp_o.exact_slot = arct_pkg::SlotW'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/address_range_claim_table_core.sv -----
// Top level of the address range claim table: request register, decision, result register.
// Depends on arct_pkg, arct_table and arct_match.
//
//   channel   handshake            payload
//   request   start_i / busy_o     command_i, range_start_i, range_end_i
//   result    done_o (strobe)      status_o, slot_o
//
// A request is taken when start_i is high and busy_o low; busy_o stays low, so one
// request per cycle is sustained. Its result strobes on done_o once it has passed the
// request register, where the slot compares act on it, and then the result register.
// The table updates on the same edge that loads the result, so the next request
// already sees it. Reset clears all used marks at once; the receiver cannot stall
// the result.
`default_nettype none

module address_range_claim_table_core #(
  parameter int unsigned TableEntries = arct_pkg::TableEntriesDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic                            command_i,
  input  wire logic [arct_pkg::AddrW-1:0]      range_start_i,
  input  wire logic [arct_pkg::AddrW-1:0]      range_end_i,
  output logic                                 done_o,
  output logic      [arct_pkg::StatusW-1:0]    status_o,
  output logic      [arct_pkg::SlotW-1:0]      slot_o
);

  logic                         req_vld_q;
  logic                         cmd_q;
  logic [arct_pkg::AddrW-1:0]   lo_q, hi_q;

  logic                         done_q;
  logic [arct_pkg::StatusW-1:0] status_q, status_d;
  logic [arct_pkg::SlotW-1:0]   slot_q, slot_d;

  arct_pkg::upd_t upd;
  arct_pkg::lkp_t lkp;

  logic [TableEntries-1:0]                      used;
  logic [TableEntries-1:0][arct_pkg::AddrW-1:0] starts;
  logic [TableEntries-1:0][arct_pkg::AddrW-1:0] ends;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q <= command_i;
      lo_q  <= range_start_i;
      hi_q  <= range_end_i;
    end
  end

  arct_table #(
    .TableEntries(TableEntries)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .used_o (used),
    .start_o(starts),
    .end_o  (ends)
  );

  arct_match #(
    .TableEntries(TableEntries)
  ) u_match (
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .used_i (used),
    .start_i(starts),
    .end_i  (ends),
    .lkp_o  (lkp)
  );

  always_comb begin
    upd      = '0;
    status_d = arct_pkg::ST_OK;
    slot_d   = '0;
    if (cmd_q == arct_pkg::CMD_CLAIM) begin
      if (lo_q > hi_q) begin
        status_d = arct_pkg::ST_ORDER;
      end else if (lkp.overlap_any) begin
        status_d = arct_pkg::ST_OVERLAP;
      end else if (!lkp.free_hit) begin
        status_d = arct_pkg::ST_FULL;
      end else begin
        slot_d    = lkp.free_slot;
        upd.claim = req_vld_q;
      end
    end else begin
      if (lkp.exact_hit) begin
        slot_d         = lkp.exact_slot;
        upd.release_en = req_vld_q;
      end else begin
        status_d = arct_pkg::ST_NOT_FOUND;
      end
    end
    upd.slot = slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      status_q <= status_d;
      slot_q   <= slot_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;

endmodule

`default_nettype wire

// ----- rtl/arct_checker.sv -----
// Port-level checks for the address range claim table, bound to the top level.
// Depends on arct_pkg for status and command codes.
`default_nettype none

module arct_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic                          command_i,
  input wire logic [arct_pkg::AddrW-1:0]    range_start_i,
  input wire logic [arct_pkg::AddrW-1:0]    range_end_i,
  input wire logic                          done_o,
  input wire logic [arct_pkg::StatusW-1:0]  status_o,
  input wire logic [arct_pkg::SlotW-1:0]    slot_o
);

  // Every accepted beat yields one result on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni && start_i && !busy_o |=> ##1 done_o)
    else $error("accepted request produced no result");

  // No result appears without an earlier accepted request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without request");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != arct_pkg::ST_OK) |-> slot_o == '0)
    else $error("failed request reported a nonzero slot");

  a_claim_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni && start_i && !busy_o && (command_i == arct_pkg::CMD_CLAIM) &&
    (range_start_i > range_end_i) |=> ##1 (status_o == arct_pkg::ST_ORDER))
    else $error("reversed claim not rejected as start after end");

  a_release_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni && start_i && !busy_o && (command_i == arct_pkg::CMD_RELEASE) &&
    (range_start_i > range_end_i) |=> ##1 (status_o == arct_pkg::ST_NOT_FOUND))
    else $error("reversed release not reported as not found");

endmodule

bind address_range_claim_table_core arct_checker u_arct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .command_i    (command_i),
  .range_start_i(range_start_i),
  .range_end_i  (range_end_i),
  .done_o       (done_o),
  .status_o     (status_o),
  .slot_o       (slot_o)
);

`default_nettype wire
